FILE: design/signed_number_seven_segment_frames_top_defines.svh
// ----------------------------------------------------------------------------
// signed_number_seven_segment_frames_top_defines.svh
// assertion macros shared by the frame encoder modules
// ----------------------------------------------------------------------------
`ifndef SIGNED_NUMBER_SEVEN_SEGMENT_FRAMES_TOP_DEFINES_SVH
`define SIGNED_NUMBER_SEVEN_SEGMENT_FRAMES_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SSF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssf: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssf: next-cycle check failed");

`endif

FILE: design/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// types, constants and small decode functions of the seven-segment frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package ssf_pkg;

  localparam int VALUE_W     = 21;
  localparam int IN_DATA_W   = 24;
  localparam int MAG_W       = 20;
  localparam int GRP_W       = 10;
  localparam int REM_W       = 7;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = 6;
  localparam int SEG_W       = 8;
  localparam int GROUP_SEG_W = 24;
  localparam int FRAME_BITS  = 36;
  localparam int WORD_BITS   = 37;
  localparam int OUT_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(999999);

  // floor(x / 1000) = (x * DIV1000_K) >> DIV1000_SHIFT for x below 2^20
  localparam int              DIV1000_SHIFT = 30;
  localparam logic [20:0]     DIV1000_K     = 21'd1073742;
  localparam int              PROD_W        = MAG_W + 21;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;

  typedef struct packed {
    logic                                neg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digit;   // digit[0] leftmost
  } ssf_rec_t;

  function automatic logic [DIGIT_W-1:0] ssf_div100(input logic [GRP_W-1:0] x);
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= GRP_W'(k * 100)) d = DIGIT_W'(k);
    end
    return d;
  endfunction

  function automatic logic [DIGIT_W-1:0] ssf_div10(input logic [REM_W-1:0] x);
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= REM_W'(k * 10)) d = DIGIT_W'(k);
    end
    return d;
  endfunction

  function automatic logic [SEG_W-1:0] ssf_seg(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // start bit in bit 0, segments zero-extended to the frame length above it
  function automatic logic [WORD_BITS-1:0] ssf_frame(input logic [GROUP_SEG_W-1:0] segs);
    logic [FRAME_BITS:0] f;
    f = {{(FRAME_BITS - GROUP_SEG_W){1'b0}}, segs, 1'b1};
    return WORD_BITS'(f);
  endfunction

endpackage

`default_nettype wire

FILE: design/signed_number_seven_segment_frames_top.sv
// ----------------------------------------------------------------------------
// signed_number_seven_segment_frames_top
// signed number to six-digit seven-segment frames for two serial led drivers
// ----------------------------------------------------------------------------
// in_*: one beat carries a 21-bit two's complement number in in_tdata[20:0].
// out_*: each number gives two beats, the low three digits first (tuser 0),
//   then the upper three digits (tuser 1, tlast 1). out_tdata[23:0] holds the
//   segment bytes, out_tdata[60:24] the 37-bit serial word with its start bit.
// magnitudes above 999999 show 999999; leading zeros are blank and a minus
//   sits left of the top digit unless all six digits are used.
// path: a number passes the front stages, the digit queue and the output
//   register; its high frame is the beat after its low frame.
// throughput: bounded by the two output beats per number on the single
//   result channel; a new number enters every cycle while the digit queue
//   has room.
// reset: synchronous, active low; clears the pipeline valids, the queue and
//   the output valid and phase. no clearing pass is needed.
// receiver stall: the output register holds its beat, the back stops
//   draining the queue, and in_tready drops while the queue is full and the
//   last digit stage holds a number.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_number_seven_segment_frames_top #(
  parameter int QUEUE_DEPTH = ssf_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssf_pkg::IN_DATA_W-1:0]   in_tdata,    // [20:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ssf_pkg::OUT_DATA_W-1:0]  out_tdata,   // [23:0] segments, [60:24] shift_word
  output logic                            out_tlast,
  output logic                            out_tuser    // [0] target_driver
);
  import ssf_pkg::*;

  ssf_rec_t push_rec;
  ssf_rec_t head_rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  ssf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  ssf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  ssf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: design/ssf_front.sv
// ----------------------------------------------------------------------------
// ssf_front
// accepts numbers, saturates the magnitude and splits it into decimal digits
// ----------------------------------------------------------------------------
`default_nettype none

module ssf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            q_full,
  output logic                            push,
  output ssf_pkg::ssf_rec_t               push_rec
);
  import ssf_pkg::*;

  logic                     en;
  logic [VALUE_W-1:0]       value;
  logic                     in_neg;
  logic [VALUE_W-1:0]       mag_full;
  logic [MAG_W-1:0]         mag_sat;
  logic [PROD_W-1:0]        prod;
  logic [MAG_W-1:0]         rem_full;

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     neg1_r, neg2_r, neg3_r, neg4_r;
  logic [MAG_W-1:0]         mag1_r, mag2_r;
  logic [GRP_W-1:0]         q2_r;
  logic [GRP_W-1:0]         hi3_r, lo3_r;
  logic [DIGIT_W-1:0]       hi_h4_r, lo_h4_r;
  logic [REM_W-1:0]         hi_rem4_r, lo_rem4_r;

  logic [DIGIT_W-1:0]       hi_t, lo_t;

  // whole pipeline holds only when the last stage cannot hand over
  assign en        = !(v4_r && q_full);
  assign in_tready = en;
  assign push      = v4_r && !q_full;

  assign value    = in_tdata[VALUE_W-1:0];
  assign in_neg   = value[VALUE_W-1];
  assign mag_full = in_neg ? (~value + VALUE_W'(1)) : value;
  assign mag_sat  = (mag_full > VALUE_W'(MAG_LIMIT)) ? MAG_LIMIT : mag_full[MAG_W-1:0];

  assign prod     = PROD_W'(mag1_r) * PROD_W'(DIV1000_K);
  assign rem_full = mag2_r - (MAG_W'(q2_r) * MAG_W'(1000));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r    <= in_neg;
      mag1_r    <= mag_sat;
      neg2_r    <= neg1_r;
      mag2_r    <= mag1_r;
      q2_r      <= prod[DIV1000_SHIFT +: GRP_W];
      neg3_r    <= neg2_r;
      hi3_r     <= q2_r;
      lo3_r     <= rem_full[GRP_W-1:0];
      neg4_r    <= neg3_r;
      hi_h4_r   <= ssf_div100(hi3_r);
      lo_h4_r   <= ssf_div100(lo3_r);
      hi_rem4_r <= REM_W'(hi3_r - (GRP_W'(ssf_div100(hi3_r)) * GRP_W'(100)));
      lo_rem4_r <= REM_W'(lo3_r - (GRP_W'(ssf_div100(lo3_r)) * GRP_W'(100)));
    end
  end

  assign hi_t = ssf_div10(hi_rem4_r);
  assign lo_t = ssf_div10(lo_rem4_r);

  always_comb begin
    push_rec.neg      = neg4_r;
    push_rec.digit[0] = hi_h4_r;
    push_rec.digit[1] = hi_t;
    push_rec.digit[2] = DIGIT_W'(hi_rem4_r - (REM_W'(hi_t) * REM_W'(10)));
    push_rec.digit[3] = lo_h4_r;
    push_rec.digit[4] = lo_t;
    push_rec.digit[5] = DIGIT_W'(lo_rem4_r - (REM_W'(lo_t) * REM_W'(10)));
  end

endmodule

`default_nettype wire

FILE: design/ssf_queue.sv
// ----------------------------------------------------------------------------
// ssf_queue
// short register queue of digit records between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_number_seven_segment_frames_top_defines.svh"

module ssf_queue #(
  parameter int DEPTH = ssf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssf_pkg::ssf_rec_t  push_rec,
  output logic               full,
  input  logic               pop,
  output ssf_pkg::ssf_rec_t  head_rec,
  output logic               empty
);
  import ssf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssf_rec_t            mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  `SSF_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full || pop)
  `SSF_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty)
  `SSF_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + CNT_W'(1))

endmodule

`default_nettype wire

FILE: design/ssf_back.sv
// ----------------------------------------------------------------------------
// ssf_back
// blanks leading zeros, places the minus, encodes segments and sends two frames
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_number_seven_segment_frames_top_defines.svh"

module ssf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssf_pkg::ssf_rec_t                 head_rec,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);
  import ssf_pkg::*;

  logic                              load;
  logic                              emit;
  logic [NUM_DIGITS-1:0]             lead;
  logic [NUM_DIGITS-1:0][SEG_W-1:0]  pos;
  logic [GROUP_SEG_W-1:0]            grp_segs;

  logic                              phase_r;
  logic                              out_valid_r;
  logic [GROUP_SEG_W-1:0]            seg_r;
  logic [WORD_BITS-1:0]              word_r;
  logic                              tgt_r;
  logic                              last_r;

  // lead[i]: every digit from the left end through i is zero; ones never blank
  always_comb begin
    lead[0] = (head_rec.digit[0] == '0);
    for (int i = 1; i < NUM_DIGITS - 1; i++) begin
      lead[i] = lead[i-1] && (head_rec.digit[i] == '0);
    end
    lead[NUM_DIGITS-1] = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (i < NUM_DIGITS - 1 && lead[i]) begin
        pos[i] = (head_rec.neg && !lead[(i + 1) % NUM_DIGITS]) ? SEG_MINUS : SEG_BLANK;
      end else begin
        pos[i] = ssf_seg(head_rec.digit[i]);
      end
    end
  end

  // low group first, then the upper three digits
  assign grp_segs = phase_r ? {pos[2], pos[1], pos[0]} : {pos[5], pos[4], pos[3]};

  assign load = !out_valid_r || out_tready;
  assign emit = load && !q_empty;
  assign pop  = emit && phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) out_valid_r <= !q_empty;
      if (emit) phase_r <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg_r  <= grp_segs;
      word_r <= ssf_frame(grp_segs);
      tgt_r  <= phase_r;
      last_r <= phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - WORD_BITS - GROUP_SEG_W){1'b0}}, word_r, seg_r};
  assign out_tlast  = last_r;
  assign out_tuser  = tgt_r;

  `SSF_ASSERT_NOW(a_tag_matches_last, clk, rst_n, out_valid_r, tgt_r == last_r)
  `SSF_ASSERT_NEXT(a_low_then_high, clk, rst_n, emit && !phase_r, phase_r && out_valid_r)
  `SSF_ASSERT_NOW(a_start_bit, clk, rst_n, out_valid_r, word_r[0])

endmodule

`default_nettype wire
